@@ rtl/multibyte_char_length_detector_top_macros.svh @@
// assertion macros shared by the checker
`ifndef MULTIBYTE_CHAR_LENGTH_DETECTOR_TOP_MACROS_SVH
`define MULTIBYTE_CHAR_LENGTH_DETECTOR_TOP_MACROS_SVH

// checked only while out of reset
`define MBCL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MBCL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mbcl_pkg.sv @@
package mbcl_pkg;

	typedef logic [2:0] mode_t;
	typedef logic [7:0] byte_t;
	typedef logic [3:0] len_t;

	localparam mode_t MODE_SINGLE  = 3'd0;
	localparam mode_t MODE_GB2312  = 3'd1;
	localparam mode_t MODE_GBK     = 3'd2;
	localparam mode_t MODE_GB18030 = 3'd3;
	localparam mode_t MODE_BIG5    = 3'd4;
	localparam mode_t MODE_UTF8    = 3'd5;
	localparam mode_t MODE_UTF16LE = 3'd6;
	localparam mode_t MODE_UTF16BE = 3'd7;

	localparam len_t LEN_NONE = 4'd0;
	localparam len_t LEN_ONE  = 4'd1;
	localparam len_t LEN_TWO  = 4'd2;
	localparam len_t LEN_FOUR = 4'd4;

	localparam logic [15:0] SURR_LO     = 16'hD800;
	localparam logic [15:0] SURR_HI_END = 16'hDBFF;
	localparam logic [15:0] SURR_LOW    = 16'hDC00;
	localparam logic [15:0] SURR_END    = 16'hDFFF;

	function automatic logic in_rng(byte_t v, byte_t lo, byte_t hi);
		return (v >= lo) && (v <= hi);
	endfunction

	function automatic logic gbk_pair(byte_t a, byte_t b);
		return in_rng(a, 8'h81, 8'hFE) && in_rng(b, 8'h40, 8'hFE) && (b != 8'h7F);
	endfunction

	function automatic len_t lead_ones(byte_t b);
		len_t n;
		logic run;
		n = '0;
		run = 1'b1;
		for (int i = 7; i >= 0; i--) begin
			if (run && b[i]) begin
				n = n + 4'd1;
			end else begin
				run = 1'b0;
			end
		end
		return n;
	endfunction

endpackage

@@ rtl/mbcl_decode.sv @@
module mbcl_decode (
	input  mbcl_pkg::mode_t mode,
	input  logic [63:0]     window,
	input  mbcl_pkg::len_t  avail,
	output mbcl_pkg::len_t  len
);
	import mbcl_pkg::*;

	byte_t       b [8];
	len_t        n_u8;
	logic        cont_ok;
	len_t        len_u8;
	logic [15:0] w1;
	logic [15:0] w2;
	len_t        len_u16;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			b[k] = window[8*k +: 8];
		end
	end

	// utf-8: leading ones of the lead byte, then continuation bytes
	always_comb begin
		n_u8 = lead_ones(b[0]);
		cont_ok = 1'b1;
		for (int k = 1; k < 8; k++) begin
			if ((4'(k) < n_u8) && (b[k][7:6] != 2'b10)) begin
				cont_ok = 1'b0;
			end
		end
		priority if (!b[0][7]) begin
			len_u8 = LEN_ONE;
		end else if (n_u8 > avail) begin
			len_u8 = LEN_NONE;
		end else if (cont_ok) begin
			len_u8 = n_u8;
		end else begin
			len_u8 = LEN_NONE;
		end
	end

	// utf-16: surrogate ranges
	always_comb begin
		if (mode == MODE_UTF16LE) begin
			w1 = {b[1], b[0]};
			w2 = {b[3], b[2]};
		end else begin
			w1 = {b[0], b[1]};
			w2 = {b[2], b[3]};
		end
		priority if (avail < 4'd2) begin
			len_u16 = LEN_NONE;
		end else if ((w1 < SURR_LO) || (w1 > SURR_END)) begin
			len_u16 = LEN_TWO;
		end else if (w1 <= SURR_HI_END) begin
			if ((avail >= 4'd4) && (w2 >= SURR_LOW) && (w2 <= SURR_END)) begin
				len_u16 = LEN_FOUR;
			end else begin
				len_u16 = LEN_NONE;
			end
		end else begin
			len_u16 = LEN_FOUR;
		end
	end

	always_comb begin
		len = LEN_NONE;
		unique case (mode)
			MODE_SINGLE: begin
				if ((avail >= 4'd1) && (b[0] != 8'h00)) len = LEN_ONE;
			end
			MODE_GB2312: begin
				if ((avail >= 4'd2)
				    && (in_rng(b[0], 8'hA1, 8'hA9) || in_rng(b[0], 8'hB0, 8'hF7))
				    && in_rng(b[1], 8'hA1, 8'hFE)) len = LEN_TWO;
			end
			MODE_GBK: begin
				if ((avail >= 4'd2) && gbk_pair(b[0], b[1])) len = LEN_TWO;
			end
			MODE_GB18030: begin
				if (avail >= 4'd2) begin
					if (gbk_pair(b[0], b[1])) begin
						len = LEN_TWO;
					end else if ((avail >= 4'd4)
					             && in_rng(b[0], 8'h81, 8'hFE) && in_rng(b[1], 8'h30, 8'h39)
					             && in_rng(b[2], 8'h81, 8'hFE) && in_rng(b[3], 8'h30, 8'h39)) begin
						len = LEN_FOUR;
					end
				end
			end
			MODE_BIG5: begin
				if ((avail >= 4'd2) && in_rng(b[0], 8'hA1, 8'hFE)
				    && (in_rng(b[1], 8'h40, 8'h7E) || in_rng(b[1], 8'hA1, 8'hFE))) len = LEN_TWO;
			end
			MODE_UTF8: begin
				len = len_u8;
			end
			MODE_UTF16LE, MODE_UTF16BE: begin
				len = len_u16;
			end
			default: begin
				len = LEN_NONE;
			end
		endcase
	end

endmodule

@@ rtl/multibyte_char_length_detector_top.sv @@
// Multibyte character length detector. Each item is an eight-byte window from
// the head of a text buffer (first byte in bits 7:0) with the count of bytes
// available; the result is the byte length of the first character under the
// rule chosen by the encoding mode register (single byte, GB2312, GBK,
// GB18030, Big5, UTF-8, UTF-16LE, UTF-16BE), or 0 when the bytes are invalid
// or too few, save UTF-8 bytes below 80h (1) and lone UTF-16 low surrogates
// (4). One item is accepted per cycle while in_ready is high, and in_ready
// depends combinationally on out_ready. Each item passes the input register,
// the byte-range decode and the result register. The mode register resets to
// single byte and must only be written while no item is in flight.
module multibyte_char_length_detector_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wen,
	input  mbcl_pkg::mode_t cfg_wdata,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [63:0]    byte_window,
	input  mbcl_pkg::len_t avail_len,
	output logic           out_valid,
	input  logic           out_ready,
	output mbcl_pkg::len_t char_len
);
	import mbcl_pkg::*;

	mode_t       mode_q;
	logic        vld_s1;
	logic [63:0] win_s1;
	len_t        avail_s1;
	logic        vld_s2;
	len_t        len_s2;
	len_t        len_dec;
	logic        adv_s2;
	logic        adv_s1;

	assign adv_s2 = !vld_s2 || out_ready;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SINGLE;
		end else if (cfg_wen) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= in_valid;
			if (adv_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			win_s1   <= byte_window;
			avail_s1 <= avail_len;
		end
		if (adv_s2 && vld_s1) begin
			len_s2 <= len_dec;
		end
	end

	mbcl_decode u_decode (
		.mode   (mode_q),
		.window (win_s1),
		.avail  (avail_s1),
		.len    (len_dec)
	);

	assign out_valid = vld_s2;
	assign char_len  = len_s2;

endmodule

@@ rtl/mbcl_checker.sv @@
`include "multibyte_char_length_detector_top_macros.svh"

module mbcl_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input mbcl_pkg::len_t char_len
);
	import mbcl_pkg::*;

	// no result during reset
	`MBCL_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "result shown during reset")

	// a stalled result holds
	`MBCL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(char_len), "stalled result changed")

	// an accepted item is followed by a shown result, after the input and result registers
	`MBCL_ASSERT(a_latency, in_valid && in_ready |=> ##1 out_valid, "accepted item gave no result")

	// a draining output never blocks the input
	`MBCL_ASSERT(a_ready_flow, out_ready |-> in_ready, "input blocked while output drains")

endmodule

bind multibyte_char_length_detector_top mbcl_checker u_mbcl_checker (.*);

@@ tb/multibyte_char_length_detector_top_tb.sv @@
`timescale 1ns / 1ps

module multibyte_char_length_detector_top_tb;
	import mbcl_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 16;
	localparam int PHASE_ITEMS = 28;
	localparam int PROBE_COUNT = 25;

	typedef struct packed {
		mode_t       mode;
		logic [63:0] win;
		len_t        avail;
		logic        fixed;
		len_t        want;
	} probe_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	mode_t       cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] byte_window;
	len_t        avail_len;
	logic        out_valid;
	logic        out_ready;
	len_t        char_len;

	len_t  char_len_due [$];
	mode_t mode_now;
	int    bad_count;
	int    cycle_count;
	bit    idle_on;

	// first byte sits in the low eight bits of the window
	probe_t probes [0:PROBE_COUNT-1] = '{
		'{MODE_SINGLE,  64'h0,                    4'd0,  1'b1, LEN_NONE},
		'{MODE_SINGLE,  64'hFFFF_FFFF_FFFF_FFFF,  4'd15, 1'b1, LEN_ONE},
		'{MODE_SINGLE,  64'hFF00,                 4'd8,  1'b1, LEN_NONE},
		'{MODE_GB2312,  64'hA1A1,                 4'd2,  1'b1, LEN_TWO},
		'{MODE_GB2312,  64'hFEF7,                 4'd8,  1'b1, LEN_TWO},
		'{MODE_GB2312,  64'hA1AA,                 4'd2,  1'b0, LEN_NONE},
		'{MODE_GB2312,  64'hA1B0,                 4'd1,  1'b0, LEN_NONE},
		'{MODE_GBK,     64'h7F81,                 4'd2,  1'b0, LEN_NONE},
		'{MODE_GBK,     64'h40FE,                 4'd2,  1'b1, LEN_TWO},
		'{MODE_GB18030, 64'h3081_3081,            4'd4,  1'b1, LEN_FOUR},
		'{MODE_GB18030, 64'h3081_3081,            4'd3,  1'b0, LEN_NONE},
		'{MODE_GB18030, 64'h39FE_39FE,            4'd8,  1'b1, LEN_FOUR},
		'{MODE_BIG5,    64'h7EA1,                 4'd2,  1'b1, LEN_TWO},
		'{MODE_BIG5,    64'h80FE,                 4'd2,  1'b0, LEN_NONE},
		'{MODE_UTF8,    64'h0,                    4'd0,  1'b1, LEN_ONE},
		'{MODE_UTF8,    64'hBF,                   4'd1,  1'b1, LEN_ONE},
		'{MODE_UTF8,    64'hAC82E2,               4'd3,  1'b0, LEN_NONE},
		'{MODE_UTF8,    64'h8080_8080_8080_80FF,  4'd8,  1'b1, 4'd8},
		'{MODE_UTF8,    64'h0080_8080_8080_80FE,  4'd6,  1'b0, LEN_NONE},
		'{MODE_UTF8,    64'h41C3,                 4'd2,  1'b0, LEN_NONE},
		'{MODE_UTF16LE, 64'hDC00,                 4'd2,  1'b1, LEN_FOUR},
		'{MODE_UTF16LE, 64'hDC00_D800,            4'd4,  1'b0, LEN_NONE},
		'{MODE_UTF16BE, 64'hFFDF_00D8,            4'd4,  1'b0, LEN_NONE},
		'{MODE_UTF16BE, 64'hFFDF_00D8,            4'd3,  1'b0, LEN_NONE},
		'{MODE_UTF16BE, 64'hFFFF,                 4'd1,  1'b0, LEN_NONE}
	};

	multibyte_char_length_detector_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_window(byte_window),
		.avail_len  (avail_len),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.char_len   (char_len)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit byte_in(byte_t v, byte_t lo, byte_t hi);
		return v >= lo && v <= hi;
	endfunction

	function automatic bit gbk_two(byte_t lead, byte_t trail);
		return byte_in(lead, 8'h81, 8'hFE) && byte_in(trail, 8'h40, 8'hFE) && trail != 8'h7F;
	endfunction

	function automatic len_t utf16_char_len(logic [15:0] u1, logic [15:0] u2, int unsigned a);
		if (a < 2)
			return LEN_NONE;
		if (u1 < SURR_LO || u1 > SURR_END)
			return LEN_TWO;
		if (u1 <= SURR_HI_END) begin
			if (a < 4 || u2 < SURR_LOW || u2 > SURR_END)
				return LEN_NONE;
		end
		return LEN_FOUR;
	endfunction

	function automatic len_t predict_char_len(mode_t m, logic [63:0] w, len_t avail);
		byte_t       b [8];
		int unsigned a;
		int unsigned n;
		len_t        r;
		for (int k = 0; k < 8; k++)
			b[k] = w[8*k +: 8];
		a = (avail > 4'd8) ? 8 : 32'(avail);
		r = LEN_NONE;
		case (m)
			MODE_GB2312: begin
				if (a >= 2 && (byte_in(b[0], 8'hA1, 8'hA9) || byte_in(b[0], 8'hB0, 8'hF7))
						&& byte_in(b[1], 8'hA1, 8'hFE))
					r = LEN_TWO;
			end
			MODE_GBK: begin
				if (a >= 2 && gbk_two(b[0], b[1]))
					r = LEN_TWO;
			end
			MODE_GB18030: begin
				if (a >= 2 && gbk_two(b[0], b[1]))
					r = LEN_TWO;
				else if (a >= 4 && byte_in(b[0], 8'h81, 8'hFE) && byte_in(b[1], 8'h30, 8'h39)
						&& byte_in(b[2], 8'h81, 8'hFE) && byte_in(b[3], 8'h30, 8'h39))
					r = LEN_FOUR;
			end
			MODE_BIG5: begin
				if (a >= 2 && byte_in(b[0], 8'hA1, 8'hFE)
						&& (byte_in(b[1], 8'h40, 8'h7E) || byte_in(b[1], 8'hA1, 8'hFE)))
					r = LEN_TWO;
			end
			MODE_UTF8: begin
				if (b[0] < 8'h80) begin
					r = LEN_ONE;
				end else begin
					n = 1;
					while (n < 8 && b[0][7 - n])
						n++;
					if (n <= a) begin
						r = len_t'(n);
						for (int k = 1; k < n; k++)
							if (b[k][7:6] != 2'b10)
								r = LEN_NONE;
					end
				end
			end
			MODE_UTF16LE: r = utf16_char_len({b[1], b[0]}, {b[3], b[2]}, a);
			MODE_UTF16BE: r = utf16_char_len({b[0], b[1]}, {b[2], b[3]}, a);
			default: begin
				if (a >= 1 && b[0] != 8'h00)
					r = LEN_ONE;
			end
		endcase
		return r;
	endfunction

	task automatic log_fault(input string msg);
		bad_count++;
		if (bad_count <= 10)
			$display("%s", msg);
	endtask

	// entered and left at a falling edge
	task automatic push_window(input logic [63:0] w, input len_t a, input bit fixed,
			input len_t want);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		byte_window <= w;
		avail_len   <= a;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		char_len_due.push_back(fixed ? want : predict_char_len(mode_now, w, a));
		@(negedge clk);
	endtask

	task automatic set_mode(input mode_t m);
		in_valid <= 1'b0;
		while (char_len_due.size() != 0)
			@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= m;
		mode_now = m;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// mostly well-formed characters for the mode, with broken bytes, short buffers and noise
	task automatic make_window(input mode_t m, output logic [63:0] w, output len_t a);
		byte_t       b [8];
		int unsigned need;
		int unsigned n;
		logic [15:0] u1;
		logic [15:0] u2;
		w = {$urandom, $urandom};
		a = len_t'($urandom_range(0, 15));
		if ($urandom_range(0, 7) == 0)
			return;
		for (int k = 0; k < 8; k++)
			b[k] = w[8*k +: 8];
		need = 2;
		case (m)
			MODE_SINGLE: need = 1;
			MODE_GB2312: begin
				b[0] = byte_t'($urandom_range(0, 1) ? $urandom_range('hA1, 'hA9)
						: $urandom_range('hB0, 'hF7));
				b[1] = byte_t'($urandom_range('hA1, 'hFE));
			end
			MODE_GBK: begin
				b[0] = byte_t'($urandom_range('h81, 'hFE));
				b[1] = byte_t'($urandom_range('h40, 'hFE));
			end
			MODE_GB18030: begin
				b[0] = byte_t'($urandom_range('h81, 'hFE));
				if ($urandom_range(0, 1)) begin
					b[1] = byte_t'($urandom_range('h40, 'hFE));
				end else begin
					b[1] = byte_t'($urandom_range('h30, 'h39));
					b[2] = byte_t'($urandom_range('h81, 'hFE));
					b[3] = byte_t'($urandom_range('h30, 'h39));
					need = 4;
				end
			end
			MODE_BIG5: begin
				b[0] = byte_t'($urandom_range('hA1, 'hFE));
				b[1] = byte_t'($urandom_range(0, 1) ? $urandom_range('h40, 'h7E)
						: $urandom_range('hA1, 'hFE));
			end
			MODE_UTF8: begin
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
				if (n == 1)
					b[0] = byte_t'($urandom_range(0, 'hBF));
				else
					b[0] = (8'hFF << (8 - n)) | (byte_t'($urandom) & (8'hFF >> (n + 1)));
				for (int k = 1; k < n; k++)
					b[k] = 8'h80 | (byte_t'($urandom) & 8'h3F);
				need = n;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: u1 = 16'($urandom_range(0, 'hD7FF));
					1: u1 = 16'($urandom_range('hE000, 'hFFFF));
					2: u1 = 16'($urandom_range('hDC00, 'hDFFF));
					default: begin
						u1 = 16'($urandom_range('hD800, 'hDBFF));
						need = 4;
					end
				endcase
				u2 = 16'($urandom_range('hDC00, 'hDFFF));
				if (m == MODE_UTF16LE) begin
					{b[1], b[0]} = u1;
					if (need == 4)
						{b[3], b[2]} = u2;
				end else begin
					{b[0], b[1]} = u1;
					if (need == 4)
						{b[2], b[3]} = u2;
				end
			end
		endcase
		if ($urandom_range(0, 5) == 0)
			b[$urandom_range(0, 3)] = byte_t'($urandom);
		case ($urandom_range(0, 5))
			0: a = len_t'(need);
			1: a = len_t'($urandom_range(0, need));
			2, 3, 4: a = len_t'($urandom_range(8, 15));
			default: ;
		endcase
		for (int k = 0; k < 8; k++)
			w[8*k +: 8] = b[k];
	endtask

	initial begin : sink_ready
		int hold;
		hold = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0)
				hold--;
			else if (idle_on && arst_n && $urandom_range(0, 5) == 0)
				hold = $urandom_range(1, 3);
			out_ready <= (hold == 0);
		end
	end

	always @(posedge clk) begin : watch_result
		len_t want;
		if (arst_n && out_valid && out_ready) begin
			if (char_len_due.size() == 0) begin
				log_fault($sformatf("unexpected item: char_len %0d", char_len));
			end else begin
				want = char_len_due.pop_front();
				if (char_len !== want)
					log_fault($sformatf("char_len mismatch: expected %0d, got %0d", want, char_len));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : run
		logic [63:0] w;
		len_t        a;
		mode_t       m;
		bad_count   = 0;
		cycle_count = 0;
		idle_on     = 1'b1;
		mode_now    = MODE_SINGLE;
		arst_n      = 1'b0;
		cfg_wen     = 1'b0;
		cfg_wdata   = MODE_SINGLE;
		in_valid    = 1'b0;
		byte_window = '0;
		avail_len   = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// first rows run on the mode left by reset
		for (int i = 0; i < PROBE_COUNT; i++) begin
			if (probes[i].mode != mode_now)
				set_mode(probes[i].mode);
			push_window(probes[i].win, probes[i].avail, probes[i].fixed, probes[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p < 8)
				m = mode_t'(p);
			else if (p == PHASES - 1)
				m = MODE_UTF16BE;
			else
				m = mode_t'($urandom_range(0, 7));
			idle_on = (p < PHASES - 3) && (p % 5 != 4);
			set_mode(m);
			repeat (PHASE_ITEMS) begin
				make_window(mode_now, w, a);
				push_window(w, a, 1'b0, LEN_NONE);
			end
		end

		in_valid <= 1'b0;
		while (char_len_due.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (char_len_due.size() != 0)
			log_fault($sformatf("%0d items never came out", char_len_due.size()));
		if (bad_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/mbcl_pkg.sv
rtl/mbcl_decode.sv
rtl/multibyte_char_length_detector_top.sv
rtl/mbcl_checker.sv
tb/multibyte_char_length_detector_top_tb.sv
